### sv/solar_pressure_torque_core_defines.svh
// Assertion macros for the solar pressure torque core.
// Included by the top level; needs aclk and aresetn in scope at the point of use.
`ifndef SOLAR_PRESSURE_TORQUE_CORE_DEFINES_SVH
`define SOLAR_PRESSURE_TORQUE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define SPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPT_ASSERT(lbl, prop, msg)
`define SPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/spt_pkg.sv
// Shared types and constants of the solar pressure torque core.
// No dependencies.
package spt_pkg;

    localparam int M_W       = 31;
    localparam int N_W       = 32;
    localparam int P_W       = 55;
    localparam int AREA_W    = 24;
    localparam int ARM_W     = 32;
    localparam int TORQUE_W  = 48;
    localparam int NORM_LAT  = 4;
    localparam int SQRT_LAT  = 32;
    localparam int DIV_LAT   = 31;
    localparam int MERGE_LAT = 7;
    localparam int CORE_LAT  = NORM_LAT + SQRT_LAT + DIV_LAT + MERGE_LAT;

    typedef enum logic [2:0] {
        CFG_AREA_X = 3'd0,
        CFG_AREA_Y = 3'd1,
        CFG_AREA_Z = 3'd2,
        CFG_PRESS  = 3'd3,
        CFG_ARM_X  = 3'd4,
        CFG_ARM_Y  = 3'd5,
        CFG_ARM_Z  = 3'd6,
        CFG_SPARE  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } spt_flags_t;

endpackage

### sv/spt_norm.sv
// Magnitude, common power-of-two normalization and sum of squares.
// Depends on spt_pkg.
module spt_norm import spt_pkg::*; #(
    parameter int VW = 32
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [VW-1:0]   sun_x,
    input  logic signed [VW-1:0]   sun_y,
    input  logic signed [VW-1:0]   sun_z,
    output spt_flags_t             flags_out,
    output logic [2:0][M_W-1:0]    m_out,
    output logic [63:0]            sum_out
);
    localparam int POS_W = $clog2(VW);

    logic [2:0][VW-1:0]  raw;
    logic [2:0][VW-1:0]  abs_reg, abs_next;
    spt_flags_t          flags_reg, flags_next;
    logic [VW-1:0]       any_w;
    logic [POS_W-1:0]    pos;
    logic [2:0][M_W-1:0] norm_reg, norm_next;
    logic [2:0][61:0]    sq_reg;
    logic [2:0][M_W-1:0] m_d1_reg, m_d2_reg;
    logic [63:0]         sum_reg;

    assign raw[0] = sun_x;
    assign raw[1] = sun_y;
    assign raw[2] = sun_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            flags_next.neg[i] = raw[i][VW-1];
            abs_next[i] = raw[i][VW-1] ? (~raw[i] + 1'b1) : raw[i];
        end
        flags_next.zero = (raw[0] == '0) && (raw[1] == '0) && (raw[2] == '0);
    end

    always_comb begin
        any_w = abs_reg[0] | abs_reg[1] | abs_reg[2];
        pos = '0;
        for (int i = 0; i < VW; i++) begin
            if (any_w[i]) pos = POS_W'(i);
        end
        for (int i = 0; i < 3; i++) begin
            norm_next[i] = M_W'({abs_reg[i], 30'b0} >> pos);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            abs_reg   <= abs_next;
            flags_reg <= flags_next;
            norm_reg  <= norm_next;
            m_d1_reg  <= norm_reg;
            m_d2_reg  <= m_d1_reg;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= 62'(norm_reg[i]) * 62'(norm_reg[i]);
            end
            sum_reg <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
        end
    end

    assign flags_out = flags_reg;
    assign m_out     = m_d2_reg;
    assign sum_out   = sum_reg;
endmodule

### sv/spt_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on spt_pkg.
module spt_sqrt import spt_pkg::*; (
    input  logic           aclk,
    input  logic           en,
    input  logic [63:0]    sum_in,
    output logic [N_W-1:0] root_out
);
    logic [63:0] v_reg [SQRT_LAT];
    logic [63:0] r_reg [SQRT_LAT];

    for (genvar s = 0; s < SQRT_LAT; s++) begin : g_stage
        logic [63:0] v_in, r_in, t, v_next, r_next;
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
        if (s == 0) begin : g_first
            assign v_in = sum_in;
            assign r_in = '0;
        end else begin : g_rest
            assign v_in = v_reg[s-1];
            assign r_in = r_reg[s-1];
        end
        always_comb begin
            t = r_in + BIT;
            if (v_in >= t) begin
                v_next = v_in - t;
                r_next = (r_in >> 1) + BIT;
            end else begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[s] <= v_next;
                r_reg[s] <= r_next;
            end
        end
    end

    assign root_out = r_reg[SQRT_LAT-1][N_W-1:0];
endmodule

### sv/spt_lane.sv
// One vector component: aligns the magnitude with the root, divides, weights the face area.
// Depends on spt_pkg.
module spt_lane import spt_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [M_W-1:0]    m_in,
    input  logic [N_W-1:0]    n_in,
    input  logic [AREA_W-1:0] area,
    output logic [M_W-1:0]    u_out,
    output logic [P_W-1:0]    p_out
);
    logic [M_W-1:0] m_dly_reg [SQRT_LAT];
    logic [N_W:0]   r_reg [DIV_LAT];
    logic [N_W-1:0] n_reg [DIV_LAT];
    logic [M_W-1:0] q_reg [DIV_LAT];
    logic [P_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_dly_reg[0] <= m_in;
            for (int i = 1; i < SQRT_LAT; i++) m_dly_reg[i] <= m_dly_reg[i-1];
        end
    end

    for (genvar j = 0; j < DIV_LAT; j++) begin : g_div
        logic [N_W:0]   t;
        logic [N_W-1:0] n_in_s;
        logic [M_W-1:0] q_in;
        logic           ge;
        if (j == 0) begin : g_first
            assign t      = (N_W + 1)'(m_dly_reg[SQRT_LAT-1]);
            assign n_in_s = n_in;
            assign q_in   = '0;
        end else begin : g_rest
            assign t      = {r_reg[j-1][N_W-1:0], 1'b0};
            assign n_in_s = n_reg[j-1];
            assign q_in   = q_reg[j-1];
        end
        assign ge = t >= (N_W + 1)'(n_in_s);
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[j] <= ge ? (t - (N_W + 1)'(n_in_s)) : t;
                n_reg[j] <= n_in_s;
                q_reg[j] <= {q_in[M_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) p_reg <= P_W'(q_reg[DIV_LAT-1]) * P_W'(area);
    end

    assign u_out = q_reg[DIV_LAT-1];
    assign p_out = p_reg;
endmodule

### sv/spt_merge.sv
// Merge of the lanes: lit area, force, signed force vector, cross product, saturation.
// Depends on spt_pkg.
module spt_merge import spt_pkg::*; (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [2:0][P_W-1:0]        p_in,
    input  logic [2:0][M_W-1:0]        u_in,
    input  spt_flags_t                 flags_in,
    input  logic [23:0]                pressure,
    input  logic signed [ARM_W-1:0]    arm_x,
    input  logic signed [ARM_W-1:0]    arm_y,
    input  logic signed [ARM_W-1:0]    arm_z,
    output logic signed [TORQUE_W-1:0] torque_x,
    output logic signed [TORQUE_W-1:0] torque_y,
    output logic signed [TORQUE_W-1:0] torque_z,
    output logic                       zero_vector
);
    localparam int F_W = 29;
    localparam int X_W = ARM_W + F_W;

    logic [2:0][M_W-1:0]       u1_reg, u2_reg, u3_reg;
    spt_flags_t                fl1_reg, fl2_reg, fl3_reg, fl4_reg, fl5_reg, fl6_reg;
    logic [26:0]               area_reg;
    logic [56:0]               area_sum;
    logic [50:0]               f_reg;
    logic [2:0][61:0]          fm_full;
    logic [2:0][27:0]          fm_reg;
    logic signed [F_W-1:0]     force_reg [3];
    logic signed [X_W-1:0]     prod_reg [6];
    logic signed [X_W:0]       diff [3];
    logic signed [X_W-7:0]     shr [3];
    logic signed [TORQUE_W-1:0] sat [3];
    logic signed [TORQUE_W-1:0] torque_reg [3];
    logic                      zero_reg;

    localparam logic signed [X_W-7:0] HI = (X_W - 6)'((64'sd1 <<< (TORQUE_W - 1)) - 1);
    localparam logic signed [X_W-7:0] LO = (X_W - 6)'(-(64'sd1 <<< (TORQUE_W - 1)));

    always_comb begin
        area_sum = 57'(p_in[0]) + 57'(p_in[1]) + 57'(p_in[2]);
        for (int i = 0; i < 3; i++) begin
            fm_full[i] = 62'(f_reg[50:20]) * 62'(u3_reg[i]);
        end
        diff[0] = (X_W + 1)'(prod_reg[0]) - (X_W + 1)'(prod_reg[1]);
        diff[1] = (X_W + 1)'(prod_reg[2]) - (X_W + 1)'(prod_reg[3]);
        diff[2] = (X_W + 1)'(prod_reg[4]) - (X_W + 1)'(prod_reg[5]);
        for (int i = 0; i < 3; i++) begin
            shr[i] = (X_W - 6)'(diff[i] >>> 7);
            if (shr[i] > HI)      sat[i] = TORQUE_W'(HI);
            else if (shr[i] < LO) sat[i] = TORQUE_W'(LO);
            else                  sat[i] = TORQUE_W'(shr[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u1_reg   <= u_in;
            fl1_reg  <= flags_in;
            area_reg <= area_sum[56:30];
            u2_reg   <= u1_reg;
            fl2_reg  <= fl1_reg;
            f_reg    <= 51'(area_reg) * 51'(pressure);
            u3_reg   <= u2_reg;
            fl3_reg  <= fl2_reg;
            for (int i = 0; i < 3; i++) fm_reg[i] <= fm_full[i][61:34];
            fl4_reg  <= fl3_reg;
            for (int i = 0; i < 3; i++) begin
                force_reg[i] <= fl4_reg.neg[i] ? -$signed(F_W'(fm_reg[i]))
                                               : $signed(F_W'(fm_reg[i]));
            end
            fl5_reg  <= fl4_reg;
            prod_reg[0] <= X_W'(arm_y) * X_W'(force_reg[2]);
            prod_reg[1] <= X_W'(arm_z) * X_W'(force_reg[1]);
            prod_reg[2] <= X_W'(arm_z) * X_W'(force_reg[0]);
            prod_reg[3] <= X_W'(arm_x) * X_W'(force_reg[2]);
            prod_reg[4] <= X_W'(arm_x) * X_W'(force_reg[1]);
            prod_reg[5] <= X_W'(arm_y) * X_W'(force_reg[0]);
            fl6_reg  <= fl5_reg;
            for (int i = 0; i < 3; i++) torque_reg[i] <= fl6_reg.zero ? '0 : sat[i];
            zero_reg <= fl6_reg.zero;
        end
    end

    assign torque_x    = torque_reg[0];
    assign torque_y    = torque_reg[1];
    assign torque_z    = torque_reg[2];
    assign zero_vector = zero_reg;
endmodule

### sv/solar_pressure_torque_core.sv
// Solar radiation pressure torque core, flat plate, top level.
// Depends on spt_pkg, spt_norm, spt_sqrt, spt_lane, spt_merge and the defines header.
//
//   port group   dir  contents
//   s_*          in   sun_x, sun_y, sun_z (VECTOR_WIDTH signed), valid/ready
//   m_*          out  torque_x/y/z (48 signed), zero_vector, valid/ready
//   cfg_*        in   wr_en, addr (3), wdata (32)
//
// One word per cycle while the output is not stalled; each word passes through
// magnitude and squares, the square-root stages, the per-lane dividers and the merge, in order.
// Reset clears the valid line and loads the register defaults.
// A stalled output word freezes the whole pipeline; s_ready follows that stall.
`include "solar_pressure_torque_core_defines.svh"
module solar_pressure_torque_core import spt_pkg::*; #(
    parameter int VECTOR_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VECTOR_WIDTH-1:0] s_sun_x,
    input  logic signed [VECTOR_WIDTH-1:0] s_sun_y,
    input  logic signed [VECTOR_WIDTH-1:0] s_sun_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [TORQUE_W-1:0]    m_torque_x,
    output logic signed [TORQUE_W-1:0]    m_torque_y,
    output logic signed [TORQUE_W-1:0]    m_torque_z,
    output logic                          m_zero_vector,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_addr,
    input  logic [31:0]                   cfg_wdata
);
    localparam int FLAG_DLY = NORM_LAT + SQRT_LAT + DIV_LAT - 1;

    logic [AREA_W-1:0]       area_reg [3];
    logic [23:0]             press_reg;
    logic signed [ARM_W-1:0] arm_x_reg, arm_y_reg, arm_z_reg;
    logic [CORE_LAT-1:0]     vld_reg;
    logic                    en;
    spt_flags_t              flags_k1;
    spt_flags_t              fl_reg [FLAG_DLY];
    logic [2:0][M_W-1:0]     m_k4, u_k67;
    logic [2:0][P_W-1:0]     p_k68;
    logic [63:0]             sum_k4;
    logic [N_W-1:0]          root;

    assign en      = !vld_reg[CORE_LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[CORE_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_reg[0] <= 24'd380842;
            area_reg[1] <= 24'd167772;
            area_reg[2] <= 24'd380842;
            press_reg   <= 24'd5009925;
            arm_x_reg   <= 32'sd6188404;
            arm_y_reg   <= -32'sd7086696;
            arm_z_reg   <= 32'sd2920793;
            vld_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_AREA_X: area_reg[0] <= cfg_wdata[AREA_W-1:0];
                    CFG_AREA_Y: area_reg[1] <= cfg_wdata[AREA_W-1:0];
                    CFG_AREA_Z: area_reg[2] <= cfg_wdata[AREA_W-1:0];
                    CFG_PRESS:  press_reg   <= cfg_wdata[23:0];
                    CFG_ARM_X:  arm_x_reg   <= cfg_wdata;
                    CFG_ARM_Y:  arm_y_reg   <= cfg_wdata;
                    CFG_ARM_Z:  arm_z_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (en) vld_reg <= {vld_reg[CORE_LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fl_reg[0] <= flags_k1;
            for (int i = 1; i < FLAG_DLY; i++) fl_reg[i] <= fl_reg[i-1];
        end
    end

    spt_norm #(.VW(VECTOR_WIDTH)) u_norm (
        .aclk      (aclk),
        .en        (en),
        .sun_x     (s_sun_x),
        .sun_y     (s_sun_y),
        .sun_z     (s_sun_z),
        .flags_out (flags_k1),
        .m_out     (m_k4),
        .sum_out   (sum_k4)
    );

    spt_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .sum_in   (sum_k4),
        .root_out (root)
    );

    for (genvar i = 0; i < 3; i++) begin : g_lane
        spt_lane u_lane (
            .aclk  (aclk),
            .en    (en),
            .m_in  (m_k4[i]),
            .n_in  (root),
            .area  (area_reg[i]),
            .u_out (u_k67[i]),
            .p_out (p_k68[i])
        );
    end

    spt_merge u_merge (
        .aclk        (aclk),
        .en          (en),
        .p_in        (p_k68),
        .u_in        (u_k67),
        .flags_in    (fl_reg[FLAG_DLY-1]),
        .pressure    (press_reg),
        .arm_x       (arm_x_reg),
        .arm_y       (arm_y_reg),
        .arm_z       (arm_z_reg),
        .torque_x    (m_torque_x),
        .torque_y    (m_torque_y),
        .torque_z    (m_torque_z),
        .zero_vector (m_zero_vector)
    );

    `SPT_ASSERT(a_zero_torque, m_valid && m_zero_vector |-> (m_torque_x == '0 && m_torque_y == '0 && m_torque_z == '0), "zero vector word carries nonzero torque")
    `SPT_ASSERT(a_ready_stall, s_ready == (!m_valid || m_ready), "input ready does not track output stall")
    `SPT_ASSERT_NEXT(a_zero_input, s_valid && s_ready && s_sun_x == '0 && s_sun_y == '0 && s_sun_z == '0, u_norm.flags_out.zero, "zero input not flagged")
endmodule
